[design/ted_pkg.sv]
`default_nettype none

package ted_pkg;

    // Detected encoding codes
    typedef enum logic [2:0] {
        KIND_ANSI     = 3'd0,
        KIND_UTF8     = 3'd1,
        KIND_UTF8_BOM = 3'd2,
        KIND_UTF16_LE = 3'd3,
        KIND_UTF16_BE = 3'd4
    } kind_t;

    // Byte order mark bytes
    localparam logic [7:0] BYTE_EF = 8'hEF;
    localparam logic [7:0] BYTE_BB = 8'hBB;
    localparam logic [7:0] BYTE_BF = 8'hBF;
    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_FE = 8'hFE;

    // Header patterns as seen in the two-byte header register
    localparam logic [15:0] HDR_UTF16_LE = {BYTE_FF, BYTE_FE};
    localparam logic [15:0] HDR_UTF16_BE = {BYTE_FE, BYTE_FF};
    localparam logic [15:0] HDR_UTF8_BOM = {BYTE_EF, BYTE_BB};

    // UTF-8 lead byte class limits
    localparam logic [7:0] LEAD_80 = 8'h80;
    localparam logic [7:0] LEAD_C0 = 8'hC0;
    localparam logic [7:0] LEAD_E0 = 8'hE0;
    localparam logic [7:0] LEAD_F0 = 8'hF0;

    // Continuation byte mask and pattern
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_BITS = 8'h80;

    // Registered input word handed to the detector core
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    // Result handed from the core to the output register
    typedef struct packed {
        logic  valid;
        kind_t kind;
    } result_t;

endpackage

`default_nettype wire

[design/ted_in_reg.sv]
`default_nettype none

module ted_in_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,
    input  wire logic             s_tlast,
    input  wire logic             take,
    output ted_pkg::in_word_t     word
);
    import ted_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    // Accept when empty or when the held word leaves this cycle
    assign s_tready = !valid_reg || take;

    // Hold the accepted word until the core takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign word.valid     = valid_reg;
    assign word.data_byte = data_reg;
    assign word.last_byte = last_reg;

endmodule

`default_nettype wire

[design/ted_core.sv]
`default_nettype none

module ted_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ted_pkg::in_word_t word,
    input  wire logic              out_free,
    output logic                   take,
    output ted_pkg::result_t       result
);
    import ted_pkg::*;

    logic [1:0]  pos_reg,  pos_next;
    logic [15:0] hdr_reg,  hdr_next;
    logic [1:0]  cont_reg, cont_next;
    logic        bad_reg,  bad_next;
    logic        fail_reg, fail_next;
    logic [7:0]  b;
    kind_t       kind;

    assign b = word.data_byte;

    // A final word needs room in the output register; others always pass
    assign take = word.valid && (!word.last_byte || out_free);

    // Update header, validator and encoding decision for one byte
    always_comb begin
        pos_next  = pos_reg;
        hdr_next  = hdr_reg;
        cont_next = cont_reg;
        bad_next  = bad_reg;
        fail_next = fail_reg;

        // Capture the first two bytes; drop a broken UTF-8 mark on the third
        case (pos_reg)
            2'd0: hdr_next = {b, 8'h00};
            2'd1: hdr_next = {hdr_reg[15:8], b};
            2'd2: begin
                if (hdr_reg == HDR_UTF8_BOM && b != BYTE_BF) begin
                    hdr_next = 16'h0000;
                end
            end
            default: hdr_next = hdr_reg;
        endcase
        if (pos_reg != 2'd3) begin
            pos_next = pos_reg + 2'd1;
        end

        // UTF-8 validator, frozen once it has failed
        if (!fail_reg) begin
            if (cont_reg != 2'd0) begin
                bad_next  = bad_reg || ((b & CONT_MASK) != CONT_BITS);
                cont_next = cont_reg - 2'd1;
                if (cont_next == 2'd0 && bad_next) begin
                    fail_next = 1'b1;
                end
            end else begin
                bad_next = 1'b0;
                if (b < LEAD_80) begin
                    cont_next = 2'd0;
                end else if (b < LEAD_C0) begin
                    fail_next = 1'b1;
                end else if (b < LEAD_E0) begin
                    cont_next = 2'd1;
                end else if (b < LEAD_F0) begin
                    cont_next = 2'd2;
                end else begin
                    fail_next = 1'b1;
                end
            end
        end

        // Marks take priority in the fixed order, then the validator verdict
        if (pos_next >= 2'd2 && hdr_next == HDR_UTF16_LE) begin
            kind = KIND_UTF16_LE;
        end else if (pos_next >= 2'd2 && hdr_next == HDR_UTF16_BE) begin
            kind = KIND_UTF16_BE;
        end else if (pos_next == 2'd3 && hdr_next == HDR_UTF8_BOM) begin
            kind = KIND_UTF8_BOM;
        end else if (!fail_next) begin
            kind = KIND_UTF8;
        end else begin
            kind = KIND_ANSI;
        end
    end

    // Advance per byte; clear everything after the final byte of a file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 2'd0;
            hdr_reg  <= 16'h0000;
            cont_reg <= 2'd0;
            bad_reg  <= 1'b0;
            fail_reg <= 1'b0;
        end else if (take) begin
            if (word.last_byte) begin
                pos_reg  <= 2'd0;
                hdr_reg  <= 16'h0000;
                cont_reg <= 2'd0;
                bad_reg  <= 1'b0;
                fail_reg <= 1'b0;
            end else begin
                pos_reg  <= pos_next;
                hdr_reg  <= hdr_next;
                cont_reg <= cont_next;
                bad_reg  <= bad_next;
                fail_reg <= fail_next;
            end
        end
    end

    assign result.valid = take && word.last_byte;
    assign result.kind  = kind;

endmodule

`default_nettype wire

[design/ted_out_reg.sv]
`default_nettype none

module ted_out_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ted_pkg::result_t result,
    output logic                  out_free,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata
);
    import ted_pkg::*;

    logic  valid_reg;
    kind_t kind_reg;

    assign out_free = !valid_reg || m_tready;

    // Hold the result word until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (result.valid) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            kind_reg <= result.kind;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b00000, kind_reg};

endmodule

`default_nettype wire

[design/text_encoding_detector.sv]
// Text encoding detector: one file byte per word, encoding code on the final byte.
// The final byte passes the input register, then the result register, before m_tvalid.
// Throughput: one byte per cycle while the result register can take a final byte; the per-byte state update is a single
// registered step between the input register and the result register.
// Reset: synchronous, active low; clears the detector state and both valid flags.
`default_nettype none

module text_encoding_detector (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,   // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [2:0] encoding_kind, [7:3] zero
);
    import ted_pkg::*;

    in_word_t word;
    result_t  result;
    logic     take;
    logic     out_free;

    ted_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .take     (take),
        .word     (word)
    );

    ted_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .word     (word),
        .out_free (out_free),
        .take     (take),
        .result   (result)
    );

    ted_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[design/ted_checker.sv]
`default_nettype none

module ted_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);
    import ted_pkg::*;

    // Reset empties the result side
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result word holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Only defined codes appear, with zero padding
    a_code_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:3] == 5'b00000) && (m_tdata[2:0] <= KIND_UTF16_BE))
        else $error("illegal encoding code");

    // A new result needs an earlier accepted final byte or an earlier stalled input
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2)
            || $past(!s_tready, 2))
        else $error("result without a final byte");

endmodule

bind text_encoding_detector ted_checker u_ted_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
